>>> rtl/tccs_pkg.sv
package tccs_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int NUM_CELLS = ROWS * COLUMNS;

  // internal widths
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(NUM_CELLS);
  localparam int LIN_W  = $clog2(NUM_CELLS + 1);

  // field widths
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int F_ROW_W   = 5;
  localparam int F_COL_W   = 7;
  localparam int F_LIN_W   = 11;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;

  // character codes and cell defaults
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;

  typedef enum logic [0:0] {
    REQ_PUT  = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BLANK
  } state_e;

  // one access to the cell memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } ram_req_t;

  // result fields, last field in the lowest bits
  typedef struct packed {
    logic [F_LIN_W-1:0] cursor_linear;
    logic [F_ROW_W-1:0] cursor_row;
    logic [F_COL_W-1:0] cursor_col;
    logic [ATTR_W-1:0]  cell_attr;
    logic [CHAR_W-1:0]  cell_char;
  } result_t;

endpackage

>>> rtl/tccs_cell_ram.sv
module tccs_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

>>> rtl/tccs_cursor_ctrl.sv
module tccs_cursor_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_valid_i,
  output logic                     s_ready_o,
  input  logic                     req_type_i,
  input  logic [7:0]               char_code_i,
  input  logic [4:0]               cell_row_i,
  input  logic [6:0]               cell_col_i,
  input  logic [7:0]               text_attr_i,
  output tccs_pkg::ram_req_t       ram_req_o,
  input  logic [tccs_pkg::CELL_W-1:0] ram_rdata_i,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output tccs_pkg::result_t        result_o
);
  import tccs_pkg::*;

  state_e             state_q, state_d;
  logic [COL_W-1:0]   cur_col_q, cur_col_d;
  logic [ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [ROW_W-1:0]   top_q, top_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic               pend_q, pend_d;
  logic [CHAR_W-1:0]  pend_char_q, pend_char_d;
  logic               rd_ok_q, rd_ok_d;
  logic               m_valid_q, m_valid_d;
  result_t            res_q, res_d;

  logic               accept;
  logic               rd_in_range;

  // put decode results
  logic [COL_W-1:0]   col_n;
  logic [ROW_W-1:0]   row_n;
  logic               wr_en;
  logic [ROW_W-1:0]   wr_row;
  logic [COL_W-1:0]   wr_col;
  logic [CHAR_W-1:0]  wr_char;
  logic               scroll;
  logic               scroll_char;

  // logical row through the circular top pointer to a memory address
  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic [ROW_W-1:0] row,
    input logic [ROW_W-1:0] top,
    input logic [COL_W-1:0] col
  );
    logic [ROW_W:0] phys;
    phys = {1'b0, row} + {1'b0, top};
    if (phys >= (ROW_W+1)'(ROWS)) begin
      phys = phys - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(int'(phys) * COLUMNS + int'(col));
  endfunction

  function automatic result_t make_result(
    input logic [CHAR_W-1:0] ch,
    input logic [ATTR_W-1:0] attr,
    input logic [COL_W-1:0]  col,
    input logic [ROW_W-1:0]  row
  );
    result_t        r;
    logic [LIN_W-1:0] lin;
    lin = LIN_W'(int'(row) * COLUMNS + int'(col));
    r.cell_char     = ch;
    r.cell_attr     = attr;
    r.cursor_col    = F_COL_W'(col);
    r.cursor_row    = F_ROW_W'(row);
    r.cursor_linear = F_LIN_W'(lin);
    return r;
  endfunction

  assign s_ready_o   = (state_q == ST_IDLE) && (!m_valid_q || m_ready_i);
  assign accept      = s_valid_i && s_ready_o;
  assign rd_in_range = (int'(cell_row_i) < ROWS) && (int'(cell_col_i) < COLUMNS);
  assign m_valid_o   = m_valid_q;
  assign result_o    = res_q;

  // cursor movement for a put request
  always_comb begin
    col_n       = cur_col_q;
    row_n       = cur_row_q;
    wr_en       = 1'b0;
    wr_row      = cur_row_q;
    wr_col      = cur_col_q;
    wr_char     = char_code_i;
    scroll      = 1'b0;
    scroll_char = 1'b0;
    case (char_code_i)
      CODE_NEWLINE: begin
        col_n = '0;
        if (cur_row_q == ROW_W'(ROWS - 1)) begin
          scroll = 1'b1;
        end else begin
          row_n = cur_row_q + 1'b1;
        end
      end
      CODE_BACKSPACE: begin
        if (cur_col_q != '0) begin
          col_n   = cur_col_q - 1'b1;
          wr_en   = 1'b1;
          wr_col  = cur_col_q - 1'b1;
          wr_char = BLANK_CHAR;
        end else if (cur_row_q != '0) begin
          row_n   = cur_row_q - 1'b1;
          col_n   = COL_W'(COLUMNS - 1);
          wr_en   = 1'b1;
          wr_row  = cur_row_q - 1'b1;
          wr_col  = COL_W'(COLUMNS - 1);
          wr_char = BLANK_CHAR;
        end
      end
      default: begin
        if (cur_col_q == COL_W'(COLUMNS)) begin
          // wrap pending: move to the next row first
          col_n = COL_W'(1);
          if (cur_row_q == ROW_W'(ROWS - 1)) begin
            scroll      = 1'b1;
            scroll_char = 1'b1;
          end else begin
            row_n  = cur_row_q + 1'b1;
            wr_en  = 1'b1;
            wr_row = cur_row_q + 1'b1;
            wr_col = '0;
          end
        end else begin
          wr_en = 1'b1;
          col_n = cur_col_q + 1'b1;
        end
      end
    endcase
  end

  // sequencer: reset clear, request handling, bottom-row blanking
  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    pend_d      = pend_q;
    pend_char_d = pend_char_q;
    rd_ok_d     = rd_ok_q;
    m_valid_d   = m_valid_q && !m_ready_i;
    res_d       = res_q;
    ram_req_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = cnt_q;
        ram_req_o.wdata = {RESET_ATTR, BLANK_CHAR};
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(NUM_CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_e'(req_type_i) == REQ_READ) begin
            rd_ok_d        = rd_in_range;
            ram_req_o.re   = rd_in_range;
            ram_req_o.addr = cell_addr(ROW_W'(cell_row_i), top_q, COL_W'(cell_col_i));
            state_d        = ST_READ;
          end else begin
            cur_col_d = col_n;
            cur_row_d = row_n;
            if (wr_en) begin
              ram_req_o.we    = 1'b1;
              ram_req_o.addr  = cell_addr(wr_row, top_q, wr_col);
              ram_req_o.wdata = {text_attr_i, wr_char};
            end
            if (scroll) begin
              // old top row becomes the new bottom row
              top_d       = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
              base_d      = cell_addr('0, top_q, '0);
              pend_d      = scroll_char;
              pend_char_d = char_code_i;
              cnt_d       = '0;
              state_d     = ST_BLANK;
            end else begin
              m_valid_d = 1'b1;
              res_d     = make_result('0, '0, col_n, row_n);
            end
          end
        end
      end
      ST_READ: begin
        m_valid_d = 1'b1;
        if (rd_ok_q) begin
          res_d = make_result(ram_rdata_i[CHAR_W-1:0], ram_rdata_i[CELL_W-1:CHAR_W],
                              cur_col_q, cur_row_q);
        end else begin
          res_d = make_result('0, '0, cur_col_q, cur_row_q);
        end
        state_d = ST_IDLE;
      end
      ST_BLANK: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = base_q + cnt_q;
        ram_req_o.wdata = {text_attr_i,
                           (pend_q && cnt_q == '0) ? pend_char_q : BLANK_CHAR};
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
          cnt_d     = '0;
          pend_d    = 1'b0;
          m_valid_d = 1'b1;
          res_d     = make_result('0, '0, cur_col_q, cur_row_q);
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cur_col_q <= '0;
      cur_row_q <= '0;
      top_q     <= '0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      top_q     <= top_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    pend_char_q <= pend_char_d;
    rd_ok_q     <= rd_ok_d;
    res_q       <= res_d;
  end

endmodule

>>> rtl/text_console_cursor_scroll.sv
// Text console engine: a grid of character cells with a cursor.
// Requests arrive on the s_axis stream: tuser selects put (0) or read (1),
// tdata carries the character and the cell position to read. Each request
// gives exactly one transfer on the m_axis stream with the read cell (zero
// for put) and the cursor after the request, plus its linear position.
// The attribute byte for written and blanked cells is set through the APB
// port at address 0; the user must write it only while the block is idle,
// and the block itself does not enforce this. A put that does not scroll
// has its result registered at the accepting edge and valid in the next cycle.
// A read passes through the registered read port of the cell memory, then
// the result register. A put that scrolls moves a circular top-row pointer,
// and the single memory port then blanks the new bottom row one cell per
// cycle, its first cell taking the pending character if the put wrapped.
// After reset the cell memory is cleared to spaces with attribute 0x07,
// one cell per cycle over all ROWS * COLUMNS (2000) cells; no request is
// taken until this ends, APB writes are taken as usual.
// When the receiver stalls the result stays in the output register; a new
// request is taken in the cycle the pending result is transferred.
module text_console_cursor_scroll (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // char_code[7:0], cell_row[12:8], cell_col[19:13]
  input  logic        s_axis_tuser_i,  // req_type
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // cell_char[7:0], cell_attr[15:8],
                                       // cursor_col[22:16], cursor_row[27:23],
                                       // cursor_linear[38:28]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tccs_pkg::*;

  logic [ATTR_W-1:0] attr_q;
  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rdata;
  result_t           result;
  logic              reg_sel;

  // attribute register
  assign pready  = 1'b1;
  assign reg_sel = !paddr[2];
  assign prdata  = reg_sel ? {{(32 - ATTR_W){1'b0}}, attr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      attr_q <= pwdata[ATTR_W-1:0];
    end
  end

  // control and cursor
  tccs_cursor_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .char_code_i (s_axis_tdata_i[7:0]),
    .cell_row_i  (s_axis_tdata_i[12:8]),
    .cell_col_i  (s_axis_tdata_i[19:13]),
    .text_attr_i (attr_q),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .result_o    (result)
  );

  // cell memory
  tccs_cell_ram #(
    .DEPTH  (NUM_CELLS),
    .WIDTH  (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W - $bits(result_t)){1'b0}}, result};

endmodule

>>> tb/sv/tb.sv
module tb;
  import tccs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 2 * COLUMNS + 8;
  localparam logic [2:0] ADDR_TEXT_ATTR = 3'd0;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;  // char_code[7:0], cell_row[12:8], cell_col[19:13]
  logic        s_tuser  = 1'b0;  // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;  // cell_char, cell_attr, cursor_col, cursor_row, cursor_linear
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // screen image, cursor and attribute as the block should hold them
  logic [CELL_W-1:0]  screen_img [NUM_CELLS];
  logic [F_COL_W-1:0] pos_col;
  logic [F_ROW_W-1:0] pos_row;
  logic [ATTR_W-1:0]  attr_byte;
  result_t            due_results [$];
  result_t            got_res;
  result_t            want_res;

  int err_count;
  int put_count;
  int read_count;
  int scroll_count;
  int wrap_count;
  int checked_count;
  int idle_cycles;
  int ready_hold;
  int ready_pick;
  int burst_left;

  always #5 clk_i = ~clk_i;

  text_console_cursor_scroll u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("mismatch at result %0d: %s expected %0d got %0d", checked_count, what, want, got);
    err_count++;
  endtask

  function automatic int cell_at(logic [F_ROW_W-1:0] row, logic [F_COL_W-1:0] col);
    return int'(row) * COLUMNS + int'(col);
  endfunction

  // move to column 0 of the next row, scrolling at the bottom
  function automatic void advance_line();
    int i;
    pos_col = '0;
    if (pos_row == ROWS - 1) begin
      for (i = 0; i < NUM_CELLS - COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
      for (i = NUM_CELLS - COLUMNS; i < NUM_CELLS; i++) screen_img[i] = {attr_byte, BLANK_CHAR};
      scroll_count++;
    end else begin
      pos_row++;
    end
  endfunction

  // apply one request to the screen image and return the result it gives
  function automatic result_t predict_console_result(req_e kind, logic [CHAR_W-1:0] ch,
                                                     logic [F_ROW_W-1:0] row,
                                                     logic [F_COL_W-1:0] col);
    result_t res;
    int lin;
    res = '0;
    if (kind == REQ_PUT) begin
      put_count++;
      if (ch == CODE_NEWLINE) begin
        advance_line();
      end else if (ch == CODE_BACKSPACE) begin
        // at top-left nothing moves; a pending wrap steps back to the last column
        if (pos_col != 0) begin
          pos_col--;
          screen_img[cell_at(pos_row, pos_col)] = {attr_byte, BLANK_CHAR};
        end else if (pos_row != 0) begin
          pos_row--;
          pos_col = F_COL_W'(COLUMNS - 1);
          screen_img[cell_at(pos_row, pos_col)] = {attr_byte, BLANK_CHAR};
        end
      end else begin
        if (pos_col >= COLUMNS) begin
          wrap_count++;
          advance_line();
        end
        screen_img[cell_at(pos_row, pos_col)] = {attr_byte, ch};
        pos_col++;
      end
    end else begin
      read_count++;
      // cells outside the grid read as zero
      if (row < ROWS && col < COLUMNS) begin
        res.cell_char = screen_img[cell_at(row, col)][CHAR_W-1:0];
        res.cell_attr = screen_img[cell_at(row, col)][CELL_W-1:CHAR_W];
      end
    end
    lin = cell_at(pos_row, pos_col);
    res.cursor_col    = pos_col;
    res.cursor_row    = pos_row;
    res.cursor_linear = lin[F_LIN_W-1:0];
    return res;
  endfunction

  // sender gaps: mostly short, a few long, with bursts of none
  function automatic int pick_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 9);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_plain_char();
    logic [CHAR_W-1:0] ch;
    do ch = CHAR_W'($urandom); while (ch == CODE_NEWLINE || ch == CODE_BACKSPACE);
    return ch;
  endfunction

  // one request transfer; returns at the edge where it is taken
  task automatic send_req(req_e kind, logic [CHAR_W-1:0] ch, logic [F_ROW_W-1:0] row,
                          logic [F_COL_W-1:0] col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, col, row, ch};
    @(negedge clk_i);
    while (!s_tready) @(negedge clk_i);
    @(posedge clk_i);
    due_results.push_back(predict_console_result(kind, ch, row, col));
  endtask

  // put with junk in the unused position fields
  task automatic send_put(logic [CHAR_W-1:0] ch);
    send_req(REQ_PUT, ch, F_ROW_W'($urandom), F_COL_W'($urandom));
  endtask

  task automatic send_random_read();
    logic [F_ROW_W-1:0] row;
    logic [F_COL_W-1:0] col;
    if ($urandom_range(0, 4) == 0) begin
      row = F_ROW_W'($urandom);
      col = F_COL_W'($urandom);
    end else begin
      row = F_ROW_W'($urandom_range(0, ROWS - 1));
      col = F_COL_W'($urandom_range(0, COLUMNS - 1));
    end
    send_req(REQ_READ, CHAR_W'($urandom), row, col);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check_read(logic [2:0] addr, logic [ATTR_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    if (prdata[ATTR_W-1:0] !== want)
      report_mismatch("text attribute readback", want, prdata[ATTR_W-1:0]);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain, let any bottom-row blanking finish, then change the attribute
  task automatic set_text_attribute(logic [ATTR_W-1:0] value);
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_write(ADDR_TEXT_ATTR, {24'b0, value});
    attr_byte = value;
    apb_check_read(ADDR_TEXT_ATTR, value);
  endtask

  // corner cases around the cursor and the grid edges
  task automatic test_directed_cases();
    send_req(REQ_READ, 8'h00, 5'd0, 7'd0);
    send_put(CODE_BACKSPACE);                 // top-left, no change
    send_put(8'h00);
    send_put(8'hFF);
    send_put(CODE_BACKSPACE);
    send_req(REQ_READ, 8'hFF, 5'd0, 7'd0);
    send_req(REQ_READ, 8'h00, 5'd0, 7'd1);
    send_put(CODE_NEWLINE);
    send_put(CODE_BACKSPACE);                 // wraps back to end of row 0
    send_put(8'h41);                          // leaves a wrap pending
    send_put(CODE_BACKSPACE);                 // back from pending wrap
    send_req(REQ_READ, 8'h00, 5'd0, 7'd79);
    send_put(8'h42);
    send_put(8'h43);                          // wraps to the next row
    send_req(REQ_READ, 8'h00, 5'd1, 7'd0);
    send_req(REQ_READ, 8'h00, 5'd24, 7'd79);
    send_req(REQ_READ, 8'h00, 5'd25, 7'd0);
    send_req(REQ_READ, 8'h00, 5'd0, 7'd80);
    send_req(REQ_READ, 8'hFF, 5'd31, 7'd127);
    send_req(REQ_READ, 8'h00, 5'd16, 7'd64);
    send_req(REQ_READ, 8'h00, 5'd24, 7'd0);
  endtask

  // text lines with random content, some long enough to wrap; scrolls often
  task automatic test_line_traffic(int n_items);
    int sent;
    int len;
    int k;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 65) len = $urandom_range(0, 60);
      else len = $urandom_range(70, 90);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) send_put(CODE_BACKSPACE);
        else if (pick < 12) send_random_read();
        else send_put(pick_plain_char());
      end
      sent += len;
      if ($urandom_range(0, 9) != 0) begin
        send_put(CODE_NEWLINE);
        sent++;
      end
    end
  endtask

  // unstructured mix of reads, characters and control codes
  task automatic test_mixed_noise(int n_items);
    int k;
    int pick;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) send_random_read();
      else if (pick < 41) send_put(CODE_NEWLINE);
      else if (pick < 49) send_put(CODE_BACKSPACE);
      else send_put(CHAR_W'($urandom));
    end
  endtask

  // result side backpressure: random stalls, some long, and ready stretches
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 60) begin
        m_tready   <= 1'b1;
        ready_hold <= $urandom_range(0, 3);
      end else if (ready_pick < 90) begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else if (ready_pick < 95) begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end else begin
        m_tready   <= 1'b1;
        ready_hold <= $urandom_range(30, 120);
      end
    end
  end

  // result check; inputs change only at rising edges, so the falling edge
  // sees the values that the next rising edge will take
  always @(negedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got_res = result_t'(m_tdata[38:0]);
      checked_count++;
      if (due_results.size() == 0) begin
        report_mismatch("unrequested result, cursor_linear", 0, got_res.cursor_linear);
      end else begin
        want_res = due_results.pop_front();
        if (got_res.cell_char !== want_res.cell_char)
          report_mismatch("cell_char", want_res.cell_char, got_res.cell_char);
        if (got_res.cell_attr !== want_res.cell_attr)
          report_mismatch("cell_attr", want_res.cell_attr, got_res.cell_attr);
        if (got_res.cursor_col !== want_res.cursor_col)
          report_mismatch("cursor_col", want_res.cursor_col, got_res.cursor_col);
        if (got_res.cursor_row !== want_res.cursor_row)
          report_mismatch("cursor_row", want_res.cursor_row, got_res.cursor_row);
        if (got_res.cursor_linear !== want_res.cursor_linear)
          report_mismatch("cursor_linear", want_res.cursor_linear, got_res.cursor_linear);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < NUM_CELLS; i++) screen_img[i] = {RESET_ATTR, BLANK_CHAR};
    pos_col   = '0;
    pos_row   = '0;
    attr_byte = RESET_ATTR;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_check_read(ADDR_TEXT_ATTR, RESET_ATTR);

    test_directed_cases();
    set_text_attribute(8'h00);
    test_line_traffic(420);
    set_text_attribute(8'hFF);
    test_mixed_noise(380);
    set_text_attribute(ATTR_W'($urandom));
    test_line_traffic(380);
    set_text_attribute(ATTR_W'($urandom));
    test_mixed_noise(350);

    // wait out the last results and any trailing blanking
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) report_mismatch("results never delivered", 0, due_results.size());

    $display("run covered %0d puts and %0d reads, %0d scrolls and %0d line wraps",
             put_count, read_count, scroll_count, wrap_count);
    $display("%0d results checked over five attribute settings, %0d mismatches",
             checked_count, err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tccs_pkg.sv
rtl/tccs_cell_ram.sv
rtl/tccs_cursor_ctrl.sv
rtl/text_console_cursor_scroll.sv
tb/sv/tb.sv
